>>> src/assert_macros.svh
// Concurrent assertion macros for the priority queue RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SPQ_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SPQ_ASSERT_SAME(label, ante, cons)
`define SPQ_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> src/spq_pkg.sv
// Shared types and constants for the stable priority queue
package spq_pkg;

  localparam int DEPTH_DEF         = 16;
  localparam int PRIORITY_BITS_DEF = 16;
  localparam int DATA_BITS_DEF     = 32;
  localparam int OCC_BITS          = 5;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_POP    = 1'b1;

  typedef struct packed {
    logic        action;
    logic [31:0] entry_data;
    logic [15:0] entry_priority;
  } spq_req_t;

  typedef struct packed {
    logic [31:0]         front_data;
    logic                front_valid;
    logic                overflow;
    logic [OCC_BITS-1:0] occupancy;
  } spq_rsp_t;

  typedef enum logic {
    ST_IDLE,
    ST_RESULT
  } spq_state_t;

  typedef struct packed {
    logic load;
    logic insert;
    logic pop;
    logic overflow;
  } spq_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } spq_status_t;

endpackage

>>> src/stable_priority_queue_unit.sv
// Stable sorted-list priority queue: top level with controller and datapath
// The result of a transaction is registered and offered in the cycle after it is accepted.
// Throughput: one transaction per cycle while results are taken; all slots compare and shift in parallel.
// A new transaction is taken in the cycle the held result is taken.
// Reset (rst, synchronous) empties the queue and drops any held result.
`include "assert_macros.svh"
module stable_priority_queue_unit import spq_pkg::*; #(
  parameter int DEPTH         = DEPTH_DEF,
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF,
  parameter int DATA_BITS     = DATA_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  spq_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output spq_rsp_t rsp
);

  spq_cmd_t    cmd;
  spq_status_t status;

  spq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req_action (req.action),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .status     (status),
    .cmd        (cmd)
  );

  spq_datapath #(
    .DEPTH         (DEPTH),
    .PRIORITY_BITS (PRIORITY_BITS),
    .DATA_BITS     (DATA_BITS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .req    (req),
    .status (status),
    .rsp    (rsp)
  );

  `SPQ_ASSERT_NEXT(a_result_follows, req_valid && req_ready, rsp_valid)
  `SPQ_ASSERT_NEXT(a_pop_returns, cmd.pop, rsp.front_valid && !rsp.overflow)
  `SPQ_ASSERT_NEXT(a_full_drops, cmd.overflow, rsp.overflow && !rsp.front_valid)
  `SPQ_ASSERT_SAME(a_single_cmd, cmd.load, !(cmd.insert && cmd.pop))

endmodule

>>> src/spq_ctrl.sv
// Handshake controller: accepts transactions and issues datapath commands
module spq_ctrl import spq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic        req_action,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  input  spq_status_t status,
  output spq_cmd_t    cmd
);

  spq_state_t state;
  spq_state_t state_next;
  logic       accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    if (accept) begin
      state_next = ST_RESULT;
    end else if (rsp_ready) begin
      state_next = ST_IDLE;
    end
  end

  always_comb begin
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        rsp_valid = 1'b0;
      end
      ST_RESULT: begin
        req_ready = rsp_ready;
        rsp_valid = 1'b1;
      end
      default: begin
        req_ready = 1'b0;
        rsp_valid = 1'b0;
      end
    endcase
    accept       = req_valid && req_ready;
    cmd.load     = accept;
    cmd.insert   = accept && (req_action == ACT_INSERT) && !status.full;
    cmd.pop      = accept && (req_action == ACT_POP) && !status.empty;
    cmd.overflow = accept && (req_action == ACT_INSERT) && status.full;
  end

endmodule

>>> src/spq_datapath.sv
// Sorted shift-register slots, entry count and result register
module spq_datapath import spq_pkg::*; #(
  parameter int DEPTH         = DEPTH_DEF,
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF,
  parameter int DATA_BITS     = DATA_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  spq_cmd_t    cmd,
  input  spq_req_t    req,
  output spq_status_t status,
  output spq_rsp_t    rsp
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_BITS-1:0]     slot_data     [DEPTH];
  logic [PRIORITY_BITS-1:0] slot_priority [DEPTH];
  logic [CW-1:0]            count;
  logic [CW-1:0]            count_next;
  logic [DEPTH-1:0]         ge;
  logic [DATA_BITS-1:0]     new_data;
  logic [PRIORITY_BITS-1:0] new_priority;

  assign new_data     = DATA_BITS'(req.entry_data);
  assign new_priority = PRIORITY_BITS'(req.entry_priority);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ge[i] = (CW'(i) < count) && (new_priority <= slot_priority[i]);
    end
  end

  always_comb begin
    status.empty = (count == '0);
    status.full  = (count == CW'(DEPTH));
    priority if (cmd.insert) begin
      count_next = count + CW'(1);
    end else if (cmd.pop) begin
      count_next = count - CW'(1);
    end else begin
      count_next = count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_slot
    logic from_new;
    if (i == 0) begin : g_head
      assign from_new = 1'b1;
    end else begin : g_body
      assign from_new = ge[i-1];
    end

    always_ff @(posedge clk) begin
      if (cmd.insert && !ge[i]) begin
        if (from_new) begin
          slot_data[i]     <= new_data;
          slot_priority[i] <= new_priority;
        end else begin
          slot_data[i]     <= slot_data[(i == 0) ? 0 : i - 1];
          slot_priority[i] <= slot_priority[(i == 0) ? 0 : i - 1];
        end
      end else if (cmd.pop && (i < DEPTH - 1)) begin
        slot_data[i]     <= slot_data[(i < DEPTH - 1) ? i + 1 : i];
        slot_priority[i] <= slot_priority[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rsp.front_data  <= cmd.pop ? 32'(slot_data[0]) : 32'd0;
      rsp.front_valid <= cmd.pop;
      rsp.overflow    <= cmd.overflow;
      rsp.occupancy   <= OCC_BITS'(count_next);
    end
  end

endmodule
